### rtl/satd_pkg.sv
// Shared constants, types and codes of the sector tag directory.
`default_nettype none

package satd_pkg;

    // Geometry; ROWS and LINE_SECTORS are powers of two.
    localparam int WAYS         = 8;
    localparam int ROWS         = 32;
    localparam int LINE_SECTORS = 4;

    localparam int SECTOR_W  = 32;
    localparam int STAMP_W   = 32;
    localparam int WAY_W     = 3;
    localparam int FUNC_W    = 2;
    localparam int OFF_W     = $clog2(LINE_SECTORS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int KEY_W     = SECTOR_W - OFF_W - ROW_W;
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = FUNC_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INVAL  = 2'd2;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [WAY_IDX_W-1:0] way_idx_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } ctl_cmd_t;

    function automatic row_t row_of(input logic [SECTOR_W-1:0] sector);
        logic [SECTOR_W-1:0] s;
        s = sector >> OFF_W;
        return s[ROW_W-1:0];
    endfunction

    function automatic key_t key_of(input logic [SECTOR_W-1:0] sector);
        logic [SECTOR_W-1:0] s;
        s = sector >> (OFF_W + ROW_W);
        return s[KEY_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/satd_ctrl.sv
// Request sequencer and output handshake of the sector tag directory.
`default_nettype none

module satd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output satd_pkg::ctl_cmd_t      cmd
);
    import satd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        s_axis_tready  = (state_reg == ST_IDLE);
        cmd.load       = s_axis_tvalid && s_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = !out_valid_reg || m_axis_tready;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    a_load_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EVAL)
        else $error("request not evaluated after load");

    a_eval_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |=> state_reg == ST_COMMIT)
        else $error("evaluate not followed by commit");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMMIT && !out_valid_reg) |=> !out_valid_reg)
        else $error("result appeared without commit");

endmodule

`default_nettype wire

### rtl/satd_datapath.sv
// Tag and stamp memories, valid bits, way match and victim choice.
`default_nettype none

module satd_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire satd_pkg::ctl_cmd_t                cmd,
    input  wire logic [satd_pkg::FUNC_W-1:0]       func,
    input  wire logic [satd_pkg::SECTOR_W-1:0]     sector_number,
    input  wire logic [satd_pkg::WAY_W-1:0]        way_select,
    output logic                                   succeeded,
    output logic [satd_pkg::WAY_W-1:0]             way_number,
    output logic                                   already_cached
);
    import satd_pkg::*;

    logic [FUNC_W-1:0] func_reg;
    logic [WAY_W-1:0]  sel_reg;
    row_t              row_reg;
    key_t              key_reg;
    row_t              rd_row;

    key_t              key_rd_reg   [WAYS];
    stamp_t            stamp_rd_reg [WAYS];
    logic [ROWS-1:0]   valid_reg    [WAYS];
    stamp_t            counter_reg;

    logic              hit_reg;
    logic              hit_next;
    way_idx_t          hit_way_reg;
    way_idx_t          hit_way_next;
    logic              free_reg;
    logic              free_next;
    way_idx_t          free_way_reg;
    way_idx_t          free_way_next;
    stamp_t            age_reg  [WAYS];
    stamp_t            age_next [WAYS];

    way_idx_t          pick;
    way_idx_t          wr_way;
    logic              key_wr;
    logic              stamp_wr;
    logic              valid_wr;
    logic              valid_val;
    logic              cnt_inc;
    logic              res_succ_next;
    logic              res_already_next;
    way_idx_t          res_way_next;

    logic              res_succ_reg;
    logic              res_already_reg;
    logic [WAY_W-1:0]  res_way_reg;

    assign rd_row = row_of(sector_number);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            sel_reg  <= way_select;
            row_reg  <= rd_row;
            key_reg  <= key_of(sector_number);
        end
    end

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        key_t   key_mem   [ROWS];
        stamp_t stamp_mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (key_wr && wr_way == WAY_IDX_W'(g))
            begin
                key_mem[row_reg] <= key_reg;
            end
            if (stamp_wr && wr_way == WAY_IDX_W'(g))
            begin
                stamp_mem[row_reg] <= counter_reg;
            end
            if (cmd.load)
            begin
                key_rd_reg[g]   <= key_mem[rd_row];
                stamp_rd_reg[g] <= stamp_mem[rd_row];
            end
        end
    end

    // Row scan: first invalid way, first key match ahead of it, wrap-corrected ages.
    always_comb
    begin
        logic run;
        run           = 1'b1;
        hit_next      = 1'b0;
        hit_way_next  = '0;
        free_next     = 1'b0;
        free_way_next = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            run = run & valid_reg[w][row_reg];
            if (!run && !free_next)
            begin
                free_next     = 1'b1;
                free_way_next = WAY_IDX_W'(w);
            end
            if (run && !hit_next && key_rd_reg[w] == key_reg)
            begin
                hit_next     = 1'b1;
                hit_way_next = WAY_IDX_W'(w);
            end
            if (stamp_rd_reg[w] > counter_reg)
            begin
                age_next[w] = ~stamp_rd_reg[w] + counter_reg;
            end
            else
            begin
                age_next[w] = counter_reg - stamp_rd_reg[w];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            hit_reg      <= hit_next;
            hit_way_reg  <= hit_way_next;
            free_reg     <= free_next;
            free_way_reg <= free_way_next;
            for (int w = 0; w < WAYS; w++)
            begin
                age_reg[w] <= age_next[w];
            end
        end
    end

    // Oldest way: positive age, beats earlier ways strictly, ties go to the lower way.
    always_comb
    begin
        logic cand;
        logic found;
        pick  = '0;
        found = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            cand = $signed(age_reg[i]) > 0;
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < i)
                begin
                    cand = cand && ($signed(age_reg[i]) > $signed(age_reg[j]));
                end
                else if (j > i)
                begin
                    cand = cand && ($signed(age_reg[i]) >= $signed(age_reg[j]));
                end
            end
            if (cand && !found)
            begin
                found = 1'b1;
                pick  = WAY_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        wr_way           = '0;
        key_wr           = 1'b0;
        stamp_wr         = 1'b0;
        valid_wr         = 1'b0;
        valid_val        = 1'b0;
        cnt_inc          = 1'b0;
        res_succ_next    = 1'b0;
        res_already_next = 1'b0;
        res_way_next     = '0;
        if (cmd.commit)
        begin
            unique case (func_reg)
                FUNC_LOOKUP:
                begin
                    if (hit_reg)
                    begin
                        wr_way        = hit_way_reg;
                        stamp_wr      = 1'b1;
                        cnt_inc       = 1'b1;
                        res_succ_next = 1'b1;
                        res_way_next  = hit_way_reg;
                    end
                end
                FUNC_ALLOC:
                begin
                    if (hit_reg)
                    begin
                        res_already_next = 1'b1;
                    end
                    else
                    begin
                        wr_way        = free_reg ? free_way_reg : pick;
                        key_wr        = 1'b1;
                        stamp_wr      = 1'b1;
                        valid_wr      = 1'b1;
                        valid_val     = 1'b1;
                        cnt_inc       = 1'b1;
                        res_succ_next = 1'b1;
                        res_way_next  = wr_way;
                    end
                end
                FUNC_INVAL:
                begin
                    if (32'(sel_reg) < WAYS)
                    begin
                        wr_way   = WAY_IDX_W'(sel_reg);
                        valid_wr = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            for (int w = 0; w < WAYS; w++)
            begin
                valid_reg[w] <= '0;
            end
        end
        else
        begin
            if (cnt_inc)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (valid_wr)
            begin
                valid_reg[wr_way][row_reg] <= valid_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_succ_reg    <= res_succ_next;
            res_already_reg <= res_already_next;
            res_way_reg     <= WAY_W'(res_way_next);
        end
    end

    assign succeeded      = res_succ_reg;
    assign way_number     = res_way_reg;
    assign already_cached = res_already_reg;

endmodule

`default_nettype wire

### rtl/set_assoc_sector_tag_directory.sv
// Top level of the set-associative sector tag directory.
//
// 8-way, 32-row tag directory for a sector cache. Each request (lookup,
// allocate or invalidate, selected by s_axis_tuser) has its result in the
// output register once it commits: the accepting edge reads the row from
// the per-way key and stamp memories, the next cycle does the parallel key
// compare and age computation, and the commit state then makes the victim
// choice and writes back key, stamp, valid bit and use counter as the
// function needs. A new request is taken in the cycle after that commit, so
// no request is accepted before the last one has committed; a result still
// held in the output register delays the commit. Every request gives exactly
// one result. Valid bits clear at reset; no clearing pass is needed.
`default_nettype none

module set_assoc_sector_tag_directory (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [31:0] sector_number, [34:32] way_select, [39:35] zero
    input  wire logic [satd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] func
    input  wire logic [satd_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] succeeded, [3:1] way_number, [4] already_cached, [7:5] zero
    output logic [satd_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);
    import satd_pkg::*;

    ctl_cmd_t          cmd;
    logic              succeeded;
    logic [WAY_W-1:0]  way_number;
    logic              already_cached;

    satd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    satd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (s_axis_tuser),
        .sector_number  (s_axis_tdata[SECTOR_W-1:0]),
        .way_select     (s_axis_tdata[SECTOR_W+WAY_W-1:SECTOR_W]),
        .succeeded      (succeeded),
        .way_number     (way_number),
        .already_cached (already_cached)
    );

    assign m_axis_tdata = {3'b000, already_cached, way_number, succeeded};

endmodule

`default_nettype wire
